// ----- rtl/core/dgs_pkg.sv -----
// ----------------------------------------------------------------------------
// dgs_pkg
// Shared sizes, codes and pipeline item types of the gradient shader.
// ----------------------------------------------------------------------------
package dgs_pkg;

  localparam int RAMP_DEPTH = 256;
  localparam int POS_BITS   = 12;

  // ramp index width, fraction width, divider layout
  localparam int IDX_W      = $clog2(RAMP_DEPTH);
  localparam int FRAC_W     = 8;
  localparam int QUO_W      = IDX_W + FRAC_W;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_BITS   = DIV_STAGES * DIV_STEPS;
  localparam int PROD_W     = POS_BITS + IDX_W;
  localparam int DVD_W      = PROD_W + 1;

  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DITHER_ON  = 2'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SHADE = 1'b1;

  typedef struct packed {
    logic                op;
    logic [POS_BITS-1:0] span;
    logic [PROD_W-1:0]   prod;
    logic [7:0]          thr;
    logic [7:0]          slot;
    logic [7:0]          color;
  } dgs_s1_t;

  typedef struct packed {
    logic                op;
    logic                zero;
    logic                sat;
    logic [7:0]          thr;
    logic [POS_BITS-1:0] span;
    logic [POS_BITS-1:0] rem;
    logic [DIV_BITS-1:0] work;
    logic [7:0]          slot;
    logic [7:0]          color;
  } dgs_div_t;

  typedef struct packed {
    logic             en;
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [7:0]       wdata;
  } dgs_ram_req_t;

endpackage

// ----- rtl/core/dgs_ram.sv -----
// ----------------------------------------------------------------------------
// dgs_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module dgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/core/dgs_front.sv -----
// ----------------------------------------------------------------------------
// dgs_front
// First two pipeline stages: scale the position, build the dither threshold,
// then form the dividend, the saturation flag and the divider start values.
// ----------------------------------------------------------------------------
module dgs_front import dgs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic                in_op,
  input  logic [POS_BITS-1:0] in_position,
  input  logic [POS_BITS-1:0] in_span,
  input  logic [11:0]         in_x_coord,
  input  logic [11:0]         in_y_coord,
  input  logic [7:0]          in_ramp_slot,
  input  logic [7:0]          in_ramp_color,
  input  logic [IDX_W-1:0]    cnt_m1,
  input  logic                dither_on,
  output logic                v_r,
  output dgs_div_t            item_r
);

  logic     s1_v_r;
  dgs_s1_t  s1_r;
  dgs_s1_t  s1_nxt;
  dgs_div_t item_nxt;

  // stage 1
  always_comb begin
    logic [7:0] x8;
    logic [7:0] y8;
    x8 = in_x_coord[7:0];
    y8 = in_y_coord[7:0];
    s1_nxt.op    = in_op;
    s1_nxt.span  = in_span;
    s1_nxt.prod  = PROD_W'(in_position * cnt_m1);
    s1_nxt.thr   = 8'((x8 & y8) * 8'd83) + 8'((x8 + y8) * 8'd63) + 8'(x8 * 8'd37);
    s1_nxt.slot  = in_ramp_slot;
    s1_nxt.color = in_ramp_color;
  end

  // stage 2: dividend is p, or p plus half the span when rounding
  always_comb begin
    logic [DVD_W-1:0] dvd;
    logic [DVD_W-1:0] lim;
    dvd = {1'b0, s1_r.prod};
    if (!dither_on) begin
      dvd = dvd + DVD_W'(s1_r.span >> 1);
    end
    lim = DVD_W'(s1_r.span) << IDX_W;
    item_nxt.op    = s1_r.op;
    item_nxt.zero  = (s1_r.span == '0);
    item_nxt.sat   = (dvd >= lim);
    item_nxt.thr   = s1_r.thr;
    item_nxt.span  = s1_r.span;
    item_nxt.rem   = POS_BITS'(dvd >> (DIV_BITS - FRAC_W));
    item_nxt.work  = {dvd[DIV_BITS-FRAC_W-1:0], {FRAC_W{1'b0}}};
    item_nxt.slot  = s1_r.slot;
    item_nxt.color = s1_r.color;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      v_r    <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      v_r    <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r   <= s1_nxt;
      item_r <= item_nxt;
    end
  end

endmodule

// ----- rtl/core/dgs_div_stage.sv -----
// ----------------------------------------------------------------------------
// dgs_div_stage
// One divider stage: a few restoring division steps, quotient bits shifted
// into the low end of the work word.
// ----------------------------------------------------------------------------
module dgs_div_stage import dgs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     v_in,
  input  dgs_div_t item_in,
  output logic     v_r,
  output dgs_div_t item_r
);

  dgs_div_t item_nxt;

  always_comb begin
    logic [POS_BITS:0] trial;
    item_nxt = item_in;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {item_nxt.rem, item_nxt.work[DIV_BITS-1]};
      if (trial >= {1'b0, item_nxt.span}) begin
        item_nxt.rem  = POS_BITS'(trial - {1'b0, item_nxt.span});
        item_nxt.work = {item_nxt.work[DIV_BITS-2:0], 1'b1};
      end else begin
        item_nxt.rem  = trial[POS_BITS-1:0];
        item_nxt.work = {item_nxt.work[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ----- rtl/core/dgs_index.sv -----
// ----------------------------------------------------------------------------
// dgs_index
// Last stage: pick the ramp index from quotient and fraction, clamp it, and
// issue the ramp access (write for write items, read for shade items).
// ----------------------------------------------------------------------------
module dgs_index import dgs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             v_in,
  input  dgs_div_t         item,
  input  logic [IDX_W-1:0] cnt_m1,
  input  logic             dither_on,
  output dgs_ram_req_t     ram_req,
  output logic             out_v_r,
  output logic             zero_r
);

  logic [IDX_W-1:0] idx;
  logic             slot_ok;

  always_comb begin
    logic [IDX_W:0] idx_ext;
    logic           bump;
    bump    = dither_on && (item.work[FRAC_W-1:0] > item.thr);
    idx_ext = {1'b0, item.work[QUO_W-1:FRAC_W]} + (IDX_W + 1)'(bump);
    if (item.sat || idx_ext > {1'b0, cnt_m1}) begin
      idx = cnt_m1;
    end else begin
      idx = idx_ext[IDX_W-1:0];
    end
  end

  // drop writes aimed past the ramp
  assign slot_ok = ({1'b0, item.slot} < 9'(RAMP_DEPTH));

  always_comb begin
    ram_req.en    = adv && v_in && ((item.op == OP_SHADE) || slot_ok);
    ram_req.we    = (item.op == OP_WRITE);
    ram_req.addr  = (item.op == OP_WRITE) ? item.slot[IDX_W-1:0] : idx;
    ram_req.wdata = item.color;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= v_in && (item.op == OP_SHADE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_r <= item.zero;
    end
  end

endmodule

// ----- rtl/core/dithered_gradient_shade.sv -----
// ----------------------------------------------------------------------------
// dithered_gradient_shade
// Ordered-dither linear gradient shader with a loadable color ramp.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall is low. A shade item's pixel color
// passes through two front stages, four divider stages of four restoring
// steps each, and the registered ramp read. The whole pipeline holds while a
// result waits under out_stall, so in_stall follows out_stall on a full
// output. Ramp write items travel the same pipeline and update the ramp at
// the read stage, so they take effect in order with the shade items around
// them; they give no result. Configuration must be written by the user only
// while the pipeline is empty; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module dithered_gradient_shade import dgs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic [POS_BITS-1:0]   in_position,
  input  logic [POS_BITS-1:0]   in_span,
  input  logic [11:0]           in_x_coord,
  input  logic [11:0]           in_y_coord,
  input  logic [7:0]            in_ramp_slot,
  input  logic [7:0]            in_ramp_color,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_pixel_color,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CFG_DATA_W-1:0] ramp_count_r;
  logic                  dither_on_r;
  logic [CFG_DATA_W-1:0] cnt_clamp;
  logic [IDX_W-1:0]      cnt_m1;
  logic                  adv;
  logic                  div_v    [DIV_STAGES+1];
  dgs_div_t              div_item [DIV_STAGES+1];
  dgs_ram_req_t          ram_req;
  logic [7:0]            ram_rdata;
  logic                  zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_count_r <= CFG_DATA_W'(1);
      dither_on_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RAMP_COUNT: ramp_count_r <= cfg_wdata;
        CFG_DITHER_ON:  dither_on_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything past the ramp as the ramp depth
  always_comb begin
    if (ramp_count_r == '0) begin
      cnt_clamp = CFG_DATA_W'(1);
    end else if (ramp_count_r > CFG_DATA_W'(RAMP_DEPTH)) begin
      cnt_clamp = CFG_DATA_W'(RAMP_DEPTH);
    end else begin
      cnt_clamp = ramp_count_r;
    end
  end
  assign cnt_m1 = IDX_W'(cnt_clamp - CFG_DATA_W'(1));

  // advance everything unless a result is held at the output
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  dgs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_valid      (in_valid),
    .in_op         (in_op),
    .in_position   (in_position),
    .in_span       (in_span),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .in_ramp_slot  (in_ramp_slot),
    .in_ramp_color (in_ramp_color),
    .cnt_m1        (cnt_m1),
    .dither_on     (dither_on_r),
    .v_r           (div_v[0]),
    .item_r        (div_item[0])
  );

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    dgs_div_stage u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .v_in    (div_v[s]),
      .item_in (div_item[s]),
      .v_r     (div_v[s+1]),
      .item_r  (div_item[s+1])
    );
  end

  dgs_index u_index (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .v_in      (div_v[DIV_STAGES]),
    .item      (div_item[DIV_STAGES]),
    .cnt_m1    (cnt_m1),
    .dither_on (dither_on_r),
    .ram_req   (ram_req),
    .out_v_r   (out_valid),
    .zero_r    (zero_r)
  );

  dgs_ram #(
    .WIDTH (8),
    .DEPTH (RAMP_DEPTH)
  ) u_ramp (
    .clk   (clk),
    .en    (ram_req.en),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  assign out_pixel_color = zero_r ? 8'd0 : ram_rdata;

endmodule

// ----- rtl/core/dgs_checker.sv -----
// ----------------------------------------------------------------------------
// dgs_checker
// Port-level checks of the gradient shader, bound to the top level.
// ----------------------------------------------------------------------------
module dgs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_pixel_color
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_color))
    else $error("stalled result changed");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // no result before an item taken just after reset has crossed all stages
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n, 7) |-> !out_valid)
    else $error("result appeared without latency");

endmodule

bind dithered_gradient_shade dgs_checker u_dgs_checker (.*);
